/* src/gcr_pkg.sv */
// gcr_pkg: shared types, constants and helpers of the grid cell reservation block
// used by gcr_div and grid_cell_reservation; depends on nothing else

package gcr_pkg;

  // grid and agent sizing
  localparam int DIM_X      = 8;
  localparam int DIM_Y      = 8;
  localparam int DIM_Z      = 4;
  localparam int MAX_AGENTS = 16;

  localparam int CELL_COUNT = DIM_X * DIM_Y * DIM_Z;
  localparam int CELL_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int AG_W       = 4;
  localparam int OWN_W      = AG_W + 1;
  localparam int PC_W       = $clog2(MAX_AGENTS + 1);
  localparam int IDX_W      = 18;
  localparam int MOV_W      = 17;
  localparam int NB_W       = 7;
  localparam int NB_LAST    = 4;

  // squared planar distance limit, 0.4 m in q8.8 squared
  localparam logic [32:0] NEAR_LIMIT_SQ = 33'd10485;

  // actions
  localparam logic [1:0] ACT_REG  = 2'd0;
  localparam logic [1:0] ACT_MOVE = 2'd1;
  localparam logic [1:0] ACT_FIND = 2'd2;

  // result status codes
  localparam logic [2:0] STS_OK      = 3'd0;
  localparam logic [2:0] STS_OUTSIDE = 3'd1;
  localparam logic [2:0] STS_TAKEN   = 3'd2;
  localparam logic [2:0] STS_NEAR    = 3'd3;
  localparam logic [2:0] STS_UNREG   = 3'd4;
  localparam logic [2:0] STS_KNOWN   = 3'd5;
  localparam logic [2:0] STS_FULL    = 3'd6;
  localparam logic [2:0] STS_NO_FREE = 3'd7;

  // configuration register indexes
  localparam logic [2:0] CFG_SIZE_X = 3'd0;
  localparam logic [2:0] CFG_SIZE_Y = 3'd1;
  localparam logic [2:0] CFG_SIZE_Z = 3'd2;
  localparam logic [2:0] CFG_OFF_X  = 3'd3;
  localparam logic [2:0] CFG_OFF_Y  = 3'd4;
  localparam logic [2:0] CFG_OFF_Z  = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DISPATCH,
    ST_SCAN_X,
    ST_SCAN_Y,
    ST_OWN_RD,
    ST_OWN_CHK,
    ST_OLD_RD,
    ST_OLD_CHK,
    ST_CLAIM,
    ST_NB_RD,
    ST_NB_CHK,
    ST_CENTRE,
    ST_OUT
  } state_t;

  // request to the shared divider
  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [14:0] divisor;
  } div_req_t;

  // neighbour step: -y, -x, +y, +x, +z
  function automatic logic signed [1:0] nb_step(input logic [2:0] k, input logic [1:0] axis);
    logic signed [1:0] s;
    s = 2'sd0;
    case (k)
      3'd0: if (axis == 2'd1) s = -2'sd1;
      3'd1: if (axis == 2'd0) s = -2'sd1;
      3'd2: if (axis == 2'd1) s = 2'sd1;
      3'd3: if (axis == 2'd0) s = 2'sd1;
      3'd4: if (axis == 2'd2) s = 2'sd1;
      default: s = 2'sd0;
    endcase
    return s;
  endfunction

  function automatic logic in_grid(input logic signed [IDX_W-1:0] x,
                                   input logic signed [IDX_W-1:0] y,
                                   input logic signed [IDX_W-1:0] z);
    return !x[IDX_W-1] && (x < DIM_X) && !y[IDX_W-1] && (y < DIM_Y) &&
           !z[IDX_W-1] && (z < DIM_Z);
  endfunction

  function automatic logic [CELL_W-1:0] cell_flat(input logic [IDX_W-1:0] x,
                                                  input logic [IDX_W-1:0] y,
                                                  input logic [IDX_W-1:0] z);
    return CELL_W'((z * DIM_Y + y) * DIM_X + x);
  endfunction

endpackage

/* src/gcr_ram.sv */
// gcr_ram: generic single write port ram with registered read
// standalone, no package dependency

module gcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/gcr_div.sv */
// gcr_div: shared restoring divider, one quotient bit per cycle
// depends on gcr_pkg for the request struct

module gcr_div (
  input  logic             clk,
  input  logic             rst_n,
  input  gcr_pkg::div_req_t req,
  output logic             done,
  output logic [15:0]      quotient
);

  logic [15:0] rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [14:0] dvs_r, dvs_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [15:0] rem_s;
  logic [16:0] trial;

  // one shift and trial subtract per cycle
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_s    = {rem_r[14:0], quo_r[15]};
    trial    = {1'b0, rem_s} - {2'b00, dvs_r};
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[16]) begin
        rem_nxt = trial[15:0];
        quo_nxt = {quo_r[14:0], 1'b1};
      end else begin
        rem_nxt = rem_s;
        quo_nxt = {quo_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* src/grid_cell_reservation.sv */
// grid_cell_reservation: top level, sequencer, agent tables and cell owner ram
// depends on gcr_pkg, gcr_div and gcr_ram
//
// Usage: requests enter on the in_ stream (in_tuser = action, in_tdata = agent and
// position), one result leaves on the out_ stream per request (out_tuser = status,
// out_tdata = target x, y, z). Registers are written on the cfg_ channel, which is
// always ready; write them only while no request is in flight.
// Each position axis goes in turn through the shared 16 step divider. After that
// a register request scans the stored points one by one and reads the owner ram;
// a move reads up to two owner entries; a find-free tries up to five neighbours
// in turn and forms the centre one axis at a time. A new request is taken once
// the sequencer is back in idle.
// The result sits in an output register: a stalled receiver holds it, the next
// request may still be taken and worked on, and its result waits until the held one
// is taken. After reset all cells are free (a valid bit per cell, cleared at once),
// no agent is known, no points are stored and the cell sizes are 1.0 m.

module grid_cell_reservation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // agent_id[3:0], pos_x[19:4], pos_y[35:20], pos_z[51:36]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // target_x[15:0], target_y[31:16], target_z[47:32]
  output logic [2:0]  out_tuser,  // status[2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW = gcr_pkg::CELL_W;
  localparam int NA = gcr_pkg::MAX_AGENTS;

  gcr_pkg::state_t state_r, state_nxt;

  logic [14:0]        size_r [3];
  logic signed [15:0] off_r [3];
  logic [14:0]        esz [3];

  logic [1:0]                      act_r;
  logic [gcr_pkg::AG_W-1:0]        agent_r;
  logic signed [15:0]              pos_r [3];
  logic signed [gcr_pkg::MOV_W-1:0] moved_r [3];
  logic signed [gcr_pkg::IDX_W-1:0] idx_r [3];
  logic signed [gcr_pkg::IDX_W-1:0] nb_r [3];
  logic signed [15:0]              tgt_r [3], tgt_nxt [3];

  logic [1:0]              axis_r, axis_nxt;
  logic [2:0]              k_r, k_nxt;
  logic [gcr_pkg::PC_W-1:0] scan_r, scan_nxt;
  logic [gcr_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                    near_r, near_nxt;
  logic [31:0]             sq_r, sq_nxt;
  logic [2:0]              sts_r, sts_nxt;
  logic [CW-1:0]           cell_r, cell_nxt;

  logic [CW-1:0]             acell_r [NA];
  logic [NA-1:0]             known_r;
  logic [15:0]               px_r [NA];
  logic [15:0]               py_r [NA];

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_sts_r;
  logic [15:0] out_tgt_r [3];
  logic        out_ld;

  logic                 ram_we;
  logic [CW-1:0]        ram_waddr, ram_raddr;
  logic [gcr_pkg::OWN_W-1:0] ram_wdata, ram_rdata, owner;
  logic [gcr_pkg::CELL_COUNT-1:0] vld_r;
  logic                 vld_rd_r;

  gcr_pkg::div_req_t div_req;
  logic              div_done;
  logic [15:0]       div_q;

  logic in_acc;
  logic idx_ld;
  logic commit;
  logic claim;
  logic nb_ld;

  logic signed [gcr_pkg::IDX_W-1:0] nx, ny, nz;
  logic signed [17:0] dx, dy;
  logic signed [35:0] sqx, sqy;
  logic [32:0]        dsum;
  logic               near_now;
  logic [gcr_pkg::NB_W-1:0] odd;
  logic [21:0]        prod;
  logic [21:0]        half;
  logic signed [23:0] ctr;
  logic [gcr_pkg::OWN_W-1:0] self_id;
  logic signed [gcr_pkg::IDX_W-1:0] q_ext;

  // shifted position, sign extended sum
  function automatic logic signed [gcr_pkg::MOV_W-1:0] MOV_W_EXT(input logic [15:0] p,
                                                                 input logic signed [15:0] o);
    return $signed({p[15], p}) + $signed({o[15], o});
  endfunction

  assign in_tready = (state_r == gcr_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign self_id   = gcr_pkg::OWN_W'(agent_r) + gcr_pkg::OWN_W'(1);
  assign owner     = vld_rd_r ? ram_rdata : '0;

  // a zero cell size counts as one
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      esz[a] = (size_r[a] == 15'd0) ? 15'd1 : size_r[a];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        size_r[a] <= 15'd256;
        off_r[a]  <= 16'sd0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gcr_pkg::CFG_SIZE_X: size_r[0] <= cfg_data[14:0];
        gcr_pkg::CFG_SIZE_Y: size_r[1] <= cfg_data[14:0];
        gcr_pkg::CFG_SIZE_Z: size_r[2] <= cfg_data[14:0];
        gcr_pkg::CFG_OFF_X:  off_r[0]  <= cfg_data;
        gcr_pkg::CFG_OFF_Y:  off_r[1]  <= cfg_data;
        gcr_pkg::CFG_OFF_Z:  off_r[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared divider
  gcr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // floor quotient from the magnitude quotient
  assign q_ext = moved_r[axis_r][gcr_pkg::MOV_W-1] ? ~{2'b00, div_q} : {2'b00, div_q};

  // cell owner store
  gcr_ram #(
    .WIDTH (gcr_pkg::OWN_W),
    .DEPTH (gcr_pkg::CELL_COUNT)
  ) u_owner (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // per cell valid bits, an invalid cell reads as free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ram_we) begin
      vld_r[ram_waddr] <= 1'b1;
    end
    vld_rd_r <= vld_r[ram_raddr];
  end

  // datapath helpers
  always_comb begin
    nx   = idx_r[0] + gcr_pkg::IDX_W'(gcr_pkg::nb_step(k_r, 2'd0));
    ny   = idx_r[1] + gcr_pkg::IDX_W'(gcr_pkg::nb_step(k_r, 2'd1));
    nz   = idx_r[2] + gcr_pkg::IDX_W'(gcr_pkg::nb_step(k_r, 2'd2));
    dx   = $signed({moved_r[0][gcr_pkg::MOV_W-1], moved_r[0]}) -
           $signed({2'b00, px_r[scan_r[gcr_pkg::AG_W-1:0]]});
    dy   = $signed({moved_r[1][gcr_pkg::MOV_W-1], moved_r[1]}) -
           $signed({2'b00, py_r[scan_r[gcr_pkg::AG_W-1:0]]});
    sqx  = dx * dx;
    sqy  = dy * dy;
    dsum = {1'b0, sq_r} + {1'b0, sqy[31:0]};
    near_now = near_r || (dsum <= gcr_pkg::NEAR_LIMIT_SQ);
    odd  = {nb_r[axis_r][gcr_pkg::NB_W-2:0], 1'b1};
    prod = 22'(odd) * 22'(esz[axis_r]);
    half = 22'((23'(prod) + 23'd1) >> 1);
    ctr  = $signed({2'b00, half}) - 24'(off_r[axis_r]);
  end

  // sequencer: next state and control
  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    k_nxt         = k_r;
    scan_nxt      = scan_r;
    pc_nxt        = pc_r;
    near_nxt      = near_r;
    sq_nxt        = sq_r;
    sts_nxt       = sts_r;
    cell_nxt      = cell_r;
    tgt_nxt       = tgt_r;
    out_valid_nxt = out_valid_r;
    out_ld        = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = cell_r;
    ram_wdata     = '0;
    ram_raddr     = cell_r;
    div_req       = '0;
    idx_ld        = 1'b0;
    commit        = 1'b0;
    claim         = 1'b0;
    nb_ld         = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      gcr_pkg::ST_IDLE: begin
        if (in_acc) begin
          axis_nxt  = 2'd0;
          sts_nxt   = gcr_pkg::STS_OK;
          near_nxt  = 1'b0;
          for (int a = 0; a < 3; a++) begin
            tgt_nxt[a] = 16'sd0;
          end
          state_nxt = gcr_pkg::ST_DIV_GO;
        end
      end
      gcr_pkg::ST_DIV_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = moved_r[axis_r][gcr_pkg::MOV_W-1] ?
                           ~moved_r[axis_r][15:0] : moved_r[axis_r][15:0];
        div_req.divisor  = esz[axis_r];
        state_nxt        = gcr_pkg::ST_DIV_WAIT;
      end
      gcr_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          idx_ld = 1'b1;
          if (axis_r == 2'd2) begin
            state_nxt = gcr_pkg::ST_DISPATCH;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = gcr_pkg::ST_DIV_GO;
          end
        end
      end
      gcr_pkg::ST_DISPATCH: begin
        cell_nxt = gcr_pkg::cell_flat(idx_r[0], idx_r[1], idx_r[2]);
        scan_nxt = '0;
        k_nxt    = '0;
        state_nxt = gcr_pkg::ST_OUT;
        case (act_r)
          gcr_pkg::ACT_REG: begin
            if (int'(agent_r) >= NA) begin
              sts_nxt = gcr_pkg::STS_FULL;
            end else if (known_r[agent_r]) begin
              sts_nxt = gcr_pkg::STS_KNOWN;
            end else if (!gcr_pkg::in_grid(idx_r[0], idx_r[1], idx_r[2])) begin
              sts_nxt = gcr_pkg::STS_OUTSIDE;
            end else if (pc_r == '0) begin
              state_nxt = gcr_pkg::ST_OWN_RD;
            end else begin
              state_nxt = gcr_pkg::ST_SCAN_X;
            end
          end
          gcr_pkg::ACT_MOVE: begin
            if (int'(agent_r) >= NA || !known_r[agent_r]) begin
              sts_nxt = gcr_pkg::STS_UNREG;
            end else if (!gcr_pkg::in_grid(idx_r[0], idx_r[1], idx_r[2])) begin
              sts_nxt = gcr_pkg::STS_OUTSIDE;
            end else begin
              state_nxt = gcr_pkg::ST_OWN_RD;
            end
          end
          gcr_pkg::ACT_FIND: state_nxt = gcr_pkg::ST_NB_RD;
          default: sts_nxt = gcr_pkg::STS_UNREG;
        endcase
      end
      gcr_pkg::ST_SCAN_X: begin
        sq_nxt    = sqx[31:0];
        state_nxt = gcr_pkg::ST_SCAN_Y;
      end
      gcr_pkg::ST_SCAN_Y: begin
        near_nxt = near_now;
        scan_nxt = scan_r + gcr_pkg::PC_W'(1);
        if (scan_r + gcr_pkg::PC_W'(1) >= pc_r) begin
          if (near_now) begin
            sts_nxt   = gcr_pkg::STS_NEAR;
            state_nxt = gcr_pkg::ST_OUT;
          end else begin
            state_nxt = gcr_pkg::ST_OWN_RD;
          end
        end else begin
          state_nxt = gcr_pkg::ST_SCAN_X;
        end
      end
      gcr_pkg::ST_OWN_RD: begin
        ram_raddr = cell_r;
        state_nxt = gcr_pkg::ST_OWN_CHK;
      end
      gcr_pkg::ST_OWN_CHK: begin
        state_nxt = gcr_pkg::ST_OUT;
        if (act_r == gcr_pkg::ACT_REG) begin
          if (owner != '0) begin
            sts_nxt = gcr_pkg::STS_TAKEN;
          end else if (int'(pc_r) >= NA) begin
            sts_nxt = gcr_pkg::STS_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = cell_r;
            ram_wdata = self_id;
            commit    = 1'b1;
            pc_nxt    = pc_r + gcr_pkg::PC_W'(1);
          end
        end else begin
          if (owner == '0) begin
            state_nxt = gcr_pkg::ST_OLD_RD;
          end else if (owner != self_id) begin
            sts_nxt = gcr_pkg::STS_TAKEN;
          end
        end
      end
      gcr_pkg::ST_OLD_RD: begin
        ram_raddr = acell_r[agent_r];
        state_nxt = gcr_pkg::ST_OLD_CHK;
      end
      gcr_pkg::ST_OLD_CHK: begin
        // free the old cell if the agent still holds it
        if (int'(acell_r[agent_r]) < gcr_pkg::CELL_COUNT && owner == self_id) begin
          ram_we    = 1'b1;
          ram_waddr = acell_r[agent_r];
          ram_wdata = '0;
        end
        state_nxt = gcr_pkg::ST_CLAIM;
      end
      gcr_pkg::ST_CLAIM: begin
        ram_we    = 1'b1;
        ram_waddr = cell_r;
        ram_wdata = self_id;
        claim     = 1'b1;
        state_nxt = gcr_pkg::ST_OUT;
      end
      gcr_pkg::ST_NB_RD: begin
        if (gcr_pkg::in_grid(nx, ny, nz)) begin
          ram_raddr = gcr_pkg::cell_flat(nx, ny, nz);
          nb_ld     = 1'b1;
          state_nxt = gcr_pkg::ST_NB_CHK;
        end else if (k_r == 3'(gcr_pkg::NB_LAST)) begin
          sts_nxt   = gcr_pkg::STS_NO_FREE;
          tgt_nxt   = pos_r;
          state_nxt = gcr_pkg::ST_OUT;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      gcr_pkg::ST_NB_CHK: begin
        if (owner == '0) begin
          axis_nxt  = 2'd0;
          state_nxt = gcr_pkg::ST_CENTRE;
        end else if (k_r == 3'(gcr_pkg::NB_LAST)) begin
          sts_nxt   = gcr_pkg::STS_NO_FREE;
          tgt_nxt   = pos_r;
          state_nxt = gcr_pkg::ST_OUT;
        end else begin
          k_nxt     = k_r + 3'd1;
          state_nxt = gcr_pkg::ST_NB_RD;
        end
      end
      gcr_pkg::ST_CENTRE: begin
        // centre of the free cell, saturated to 16 bits
        if (ctr > 24'sd32767) begin
          tgt_nxt[axis_r] = 16'sd32767;
        end else if (ctr < -24'sd32768) begin
          tgt_nxt[axis_r] = -16'sd32768;
        end else begin
          tgt_nxt[axis_r] = ctr[15:0];
        end
        if (axis_r == 2'd2) begin
          state_nxt = gcr_pkg::ST_OUT;
        end else begin
          axis_nxt = axis_r + 2'd1;
        end
      end
      gcr_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_ld        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = gcr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gcr_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gcr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
      known_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pc_r        <= pc_nxt;
      if (commit) begin
        known_r[agent_r] <= 1'b1;
      end
    end
  end

  // working registers and tables
  always_ff @(posedge clk) begin
    axis_r <= axis_nxt;
    k_r    <= k_nxt;
    scan_r <= scan_nxt;
    near_r <= near_nxt;
    sq_r   <= sq_nxt;
    sts_r  <= sts_nxt;
    cell_r <= cell_nxt;
    tgt_r  <= tgt_nxt;
    if (in_acc) begin
      act_r    <= in_tuser;
      agent_r  <= in_tdata[3:0];
      pos_r[0] <= in_tdata[19:4];
      pos_r[1] <= in_tdata[35:20];
      pos_r[2] <= in_tdata[51:36];
      moved_r[0] <= MOV_W_EXT(in_tdata[19:4], off_r[0]);
      moved_r[1] <= MOV_W_EXT(in_tdata[35:20], off_r[1]);
      moved_r[2] <= MOV_W_EXT(in_tdata[51:36], off_r[2]);
    end
    if (idx_ld) begin
      idx_r[axis_r] <= q_ext;
    end
    if (nb_ld) begin
      nb_r[0] <= nx;
      nb_r[1] <= ny;
      nb_r[2] <= nz;
    end
    if (commit) begin
      acell_r[agent_r] <= cell_r;
      px_r[pc_r[gcr_pkg::AG_W-1:0]] <= moved_r[0][15:0];
      py_r[pc_r[gcr_pkg::AG_W-1:0]] <= moved_r[1][15:0];
    end
    if (claim) begin
      acell_r[agent_r] <= cell_r;
    end
    if (out_ld) begin
      out_sts_r <= sts_r;
      for (int a = 0; a < 3; a++) begin
        out_tgt_r[a] <= tgt_r[a];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_sts_r;
  assign out_tdata  = {out_tgt_r[2], out_tgt_r[1], out_tgt_r[0]};

`ifndef SYNTH
  a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(pc_r) <= NA)
    else $error("stored point count above agent limit");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == gcr_pkg::ST_OUT))
    else $error("result raised outside of the output step");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == gcr_pkg::ST_DIV_WAIT)
    else $error("divider finished while not awaited");

  a_claim_known: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_wdata != '0) |=> known_r[$past(agent_r)])
    else $error("cell claimed by an unknown agent");
`endif

endmodule
